// ===== rtl/ssgr_pkg.sv =====
package ssgr_pkg;

	localparam int DIV_W      = 16;
	localparam int SPEED_W    = 16;
	localparam int RAMP_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int POS_OUT_W  = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS  = 2'd2;

	localparam logic [SPEED_W-1:0] TICK_RATE_RST   = 16'd1000;
	localparam logic [SPEED_W-1:0] START_SPEED_RST = 16'd50;
	localparam logic [RAMP_W-1:0]  RAMP_TICKS_RST  = 8'd5;

	typedef enum logic [2:0] {
		ACT_TICK,
		ACT_UP,
		ACT_DOWN,
		ACT_STOP,
		ACT_ESTOP,
		ACT_CLEAR,
		ACT_ZERO,
		ACT_POLL
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_UP,
		MODE_DOWN,
		MODE_ERROR
	} mode_t;

	// decoded command as it sits in the queue
	typedef struct packed {
		action_t              action;
		logic [SPEED_W-1:0]   speed;
		logic                 limit_top;
		logic                 limit_bottom;
		logic                 is_move;
		logic                 move_up;
		logic                 move_lim;
		logic                 speed_zero;
	} cmd_t;

	typedef struct packed {
		logic                        step_level;
		logic                        dir_up;
		logic                        driver_disabled;
		mode_t                       motor_state;
		logic signed [POS_OUT_W-1:0] position;
		logic                        command_ignored;
	} res_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== rtl/stepper_step_generator_ramp_unit.sv =====
// channel   direction  handshake            payload
// command   in         push / full          action, speed, limit_top, limit_bottom
// result    out        empty / pop          step_level, dir_up, driver_disabled,
//                                           motor_state, position, command_ignored
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// non-move items pass the input register and command queue and are executed by the back end,
// one item per cycle sustained while the result queue has room and no move is running
// an accepted move runs two 16-step divisions on the shared radix-2 divider
// reset is asynchronous; control state and the config registers load their defaults at once
// full rises when the input register and the two-entry command queue are occupied;
// results wait in a two-entry queue, and the executor holds while that queue is full
module stepper_step_generator_ramp_unit #(
	parameter int POSITION_BITS = 32,
	parameter int PERIOD_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [2:0]                          action,
	input  logic [ssgr_pkg::SPEED_W-1:0]        speed,
	input  logic                                limit_top,
	input  logic                                limit_bottom,
	output logic                                empty,
	input  logic                                pop,
	output logic                                step_level,
	output logic                                dir_up,
	output logic                                driver_disabled,
	output logic [1:0]                          motor_state,
	output logic signed [ssgr_pkg::POS_OUT_W-1:0] position,
	output logic                                command_ignored,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssgr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssgr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CMD_W = $bits(ssgr_pkg::cmd_t);
	localparam int RES_W = $bits(ssgr_pkg::res_t);

	logic                       q_push, q_full, cmd_empty, cmd_pop;
	ssgr_pkg::cmd_t             q_data, cmd_head;
	logic                       res_push, res_full;
	ssgr_pkg::res_t             res_in, res_out;
	ssgr_pkg::cfg_wr_t          cfg_wr;
	logic                       div_start, div_done;
	logic [ssgr_pkg::DIV_W-1:0] div_dividend, div_divisor, div_quotient;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	ssgr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.speed        (speed),
		.limit_top    (limit_top),
		.limit_bottom (limit_bottom),
		.q_push       (q_push),
		.q_data       (q_data),
		.q_full       (q_full)
	);

	ssgr_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_data),
		.full   (q_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	ssgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	ssgr_back #(
		.POSITION_BITS (POSITION_BITS),
		.PERIOD_BITS   (PERIOD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_wr),
		.cmd_valid    (!cmd_empty),
		.cmd          (cmd_head),
		.cmd_pop      (cmd_pop),
		.res_full     (res_full),
		.res_push     (res_push),
		.res          (res_in),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient)
	);

	ssgr_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign step_level      = res_out.step_level;
	assign dir_up          = res_out.dir_up;
	assign driver_disabled = res_out.driver_disabled;
	assign motor_state     = res_out.motor_state;
	assign position        = res_out.position;
	assign command_ignored = res_out.command_ignored;

endmodule

// ===== rtl/ssgr_fifo.sv =====
module ssgr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== rtl/ssgr_front.sv =====
module ssgr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [2:0]                        action,
	input  logic [ssgr_pkg::SPEED_W-1:0]      speed,
	input  logic                              limit_top,
	input  logic                              limit_bottom,
	output logic                              q_push,
	output ssgr_pkg::cmd_t                    q_data,
	input  logic                              q_full
);

	logic           valid_s1;
	ssgr_pkg::cmd_t cmd_s1;
	ssgr_pkg::cmd_t dec;
	logic           accept;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_full;
	assign q_data = cmd_s1;

	always_comb begin
		dec.action       = ssgr_pkg::action_t'(action);
		dec.speed        = speed;
		dec.limit_top    = limit_top;
		dec.limit_bottom = limit_bottom;
		dec.is_move      = (dec.action == ssgr_pkg::ACT_UP) || (dec.action == ssgr_pkg::ACT_DOWN);
		dec.move_up      = (dec.action == ssgr_pkg::ACT_UP);
		dec.speed_zero   = (speed == '0);
		// limit that blocks this move direction
		priority if (dec.action == ssgr_pkg::ACT_UP) dec.move_lim = limit_top;
		else if (dec.action == ssgr_pkg::ACT_DOWN) dec.move_lim = limit_bottom;
		else dec.move_lim = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cmd_s1 <= dec;
	end

endmodule

// ===== rtl/ssgr_div.sv =====
module ssgr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ssgr_pkg::DIV_W-1:0]   dividend,
	input  logic [ssgr_pkg::DIV_W-1:0]   divisor,
	output logic                         done,
	output logic [ssgr_pkg::DIV_W-1:0]   quotient
);

	localparam int W     = ssgr_pkg::DIV_W;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q, quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [W+1:0]     trial;

	// restoring radix-2 step, one quotient bit per cycle
	assign trial    = {1'b0, rem_q, quo_q[W-1]} - {2'b00, divisor};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[W+1]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== rtl/ssgr_back.sv =====
module ssgr_back #(
	parameter int POSITION_BITS = 32,
	parameter int PERIOD_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssgr_pkg::cfg_wr_t             cfg,
	input  logic                          cmd_valid,
	input  ssgr_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	input  logic                          res_full,
	output logic                          res_push,
	output ssgr_pkg::res_t                res,
	output logic                          div_start,
	output logic [ssgr_pkg::DIV_W-1:0]    div_dividend,
	output logic [ssgr_pkg::DIV_W-1:0]    div_divisor,
	input  logic                          div_done,
	input  logic [ssgr_pkg::DIV_W-1:0]    div_quotient
);

	localparam logic [32:0] PER_MAX = (33'd1 << PERIOD_BITS) - 33'd1;
	localparam logic [PERIOD_BITS-1:0]   PER_ONE = PERIOD_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	typedef enum logic [1:0] {
		B_IDLE,
		B_START,
		B_GOAL
	} bstate_t;

	typedef struct packed {
		ssgr_pkg::mode_t                mode;
		logic [POSITION_BITS-1:0]       step_count;
		logic [PERIOD_BITS-1:0]         active;
		logic [PERIOD_BITS-1:0]         countdown;
		logic [PERIOD_BITS-1:0]         goal;
		logic [PERIOD_BITS-1:0]         ramp;
		logic [ssgr_pkg::RAMP_W-1:0]    ramp_cnt;
		logic                           pulse;
		logic                           dir_up;
		logic                           disabled;
	} st_t;

	bstate_t                        state_q;
	st_t                            st_q, nx;
	logic [ssgr_pkg::SPEED_W-1:0]   tick_rate_q, start_speed_q;
	logic [ssgr_pkg::RAMP_W-1:0]    ramp_ticks_q;
	ssgr_pkg::cmd_t                 cmd_q;
	logic [PERIOD_BITS-1:0]         start_p_q;
	logic [PERIOD_BITS-1:0]         goal_p, move_start;
	logic                           div_start_q;
	logic [ssgr_pkg::DIV_W-1:0]     div_divisor_q;
	logic                           move_go, hit, ignored;
	logic signed [63:0]             pos_wide;

	// quotient to period: zero speed gives 0, clamp to 1, saturate to the period width
	function automatic logic [PERIOD_BITS-1:0] period_of(input logic zero,
	                                                     input logic [ssgr_pkg::DIV_W-1:0] q);
		logic [32:0] wide;
		wide = {17'd0, q};
		if (q == '0) wide = 33'd1;
		if (wide > PER_MAX) wide = PER_MAX;
		if (zero) wide = '0;
		return wide[PERIOD_BITS-1:0];
	endfunction

	assign div_start    = div_start_q;
	assign div_dividend = tick_rate_q;
	assign div_divisor  = div_divisor_q;

	assign goal_p     = period_of(cmd_q.speed_zero, div_quotient);
	assign move_start = (start_p_q < goal_p) ? goal_p : start_p_q;
	assign hit        = ((st_q.mode == ssgr_pkg::MODE_UP) && cmd.limit_top) ||
	                    ((st_q.mode == ssgr_pkg::MODE_DOWN) && cmd.limit_bottom);

	always_comb begin
		nx       = st_q;
		ignored  = 1'b0;
		res_push = 1'b0;
		cmd_pop  = 1'b0;
		move_go  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					if (cmd.is_move && (st_q.mode != ssgr_pkg::MODE_ERROR) && !cmd.move_lim) begin
						move_go = 1'b1;
					end else begin
						res_push = 1'b1;
						unique case (cmd.action)
							ssgr_pkg::ACT_TICK: begin
								if (st_q.active != '0) begin
									if (hit) begin
										nx.active = '0;
										nx.mode   = ssgr_pkg::MODE_IDLE;
										nx.pulse  = 1'b0;
									end else begin
										if (st_q.ramp_cnt != '0) begin
											nx.ramp_cnt = st_q.ramp_cnt - 1'b1;
										end else begin
											nx.ramp_cnt = ramp_ticks_q;
											if (st_q.ramp > st_q.goal) begin
												nx.ramp   = st_q.ramp - PER_ONE;
												nx.active = st_q.ramp - PER_ONE;
											end
										end
										if (st_q.countdown != '0) begin
											nx.countdown = st_q.countdown - PER_ONE;
										end else begin
											nx.countdown = nx.active;
											nx.pulse     = !st_q.pulse;
											// position counts on the rising edge only
											if (!st_q.pulse) begin
												if (st_q.mode == ssgr_pkg::MODE_UP)
													nx.step_count = st_q.step_count + POS_ONE;
												else if (st_q.mode == ssgr_pkg::MODE_DOWN)
													nx.step_count = st_q.step_count - POS_ONE;
											end
										end
									end
								end
							end
							ssgr_pkg::ACT_UP, ssgr_pkg::ACT_DOWN: begin
								ignored = 1'b1;
							end
							ssgr_pkg::ACT_STOP: begin
								nx.active = '0;
								nx.mode   = ssgr_pkg::MODE_IDLE;
								nx.pulse  = 1'b0;
							end
							ssgr_pkg::ACT_ESTOP: begin
								nx.active   = '0;
								nx.mode     = ssgr_pkg::MODE_ERROR;
								nx.pulse    = 1'b0;
								nx.disabled = 1'b1;
							end
							ssgr_pkg::ACT_CLEAR: begin
								if (st_q.mode == ssgr_pkg::MODE_ERROR) nx.mode = ssgr_pkg::MODE_IDLE;
								nx.disabled = 1'b0;
							end
							ssgr_pkg::ACT_ZERO: begin
								nx.step_count = '0;
							end
							ssgr_pkg::ACT_POLL: begin
								if (hit) begin
									nx.active = '0;
									nx.mode   = ssgr_pkg::MODE_IDLE;
									nx.pulse  = 1'b0;
								end
							end
						endcase
					end
				end
			end
			B_START: begin
			end
			B_GOAL: begin
				if (div_done) begin
					res_push     = 1'b1;
					nx.dir_up    = cmd_q.move_up;
					nx.goal      = goal_p;
					nx.ramp      = move_start;
					nx.active    = move_start;
					nx.countdown = move_start;
					nx.ramp_cnt  = ramp_ticks_q;
					nx.mode      = cmd_q.move_up ? ssgr_pkg::MODE_UP : ssgr_pkg::MODE_DOWN;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		pos_wide            = 64'(signed'(nx.step_count));
		res.step_level      = nx.pulse;
		res.dir_up          = nx.dir_up;
		res.driver_disabled = nx.disabled;
		res.motor_state     = nx.mode;
		res.position        = pos_wide[ssgr_pkg::POS_OUT_W-1:0];
		res.command_ignored = ignored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			st_q        <= '0;
			div_start_q <= 1'b0;
		end else begin
			st_q        <= nx;
			div_start_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (move_go) begin
						state_q     <= B_START;
						div_start_q <= 1'b1;
					end
				end
				B_START: begin
					if (div_done) begin
						state_q     <= B_GOAL;
						div_start_q <= 1'b1;
					end
				end
				B_GOAL: begin
					if (div_done) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (move_go) begin
			cmd_q         <= cmd;
			div_divisor_q <= start_speed_q;
		end
		if ((state_q == B_START) && div_done) begin
			start_p_q     <= period_of(start_speed_q == '0, div_quotient);
			div_divisor_q <= cmd_q.speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q   <= ssgr_pkg::TICK_RATE_RST;
			start_speed_q <= ssgr_pkg::START_SPEED_RST;
			ramp_ticks_q  <= ssgr_pkg::RAMP_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ssgr_pkg::CFG_TICK_RATE:   tick_rate_q   <= cfg.data;
				ssgr_pkg::CFG_START_SPEED: start_speed_q <= cfg.data;
				ssgr_pkg::CFG_RAMP_TICKS:  ramp_ticks_q  <= cfg.data[ssgr_pkg::RAMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/ssgr_checker.sv =====
module ssgr_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 empty,
	input logic                                 pop,
	input logic                                 step_level,
	input logic                                 dir_up,
	input logic                                 driver_disabled,
	input logic [1:0]                           motor_state,
	input logic signed [ssgr_pkg::POS_OUT_W-1:0] position,
	input logic                                 command_ignored
);

	// error mode always comes with the driver disabled
	a_error_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (motor_state == ssgr_pkg::MODE_ERROR)) |-> driver_disabled)
		else $error("error mode with driver enabled");

	// a halted motor never shows a high step level
	a_halt_low: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ((motor_state == ssgr_pkg::MODE_IDLE) ||
		            (motor_state == ssgr_pkg::MODE_ERROR))) |-> !step_level)
		else $error("step level high while halted");

	// moving mode and direction output agree
	a_dir_match: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ((motor_state == ssgr_pkg::MODE_UP) ||
		            (motor_state == ssgr_pkg::MODE_DOWN))) |->
		(dir_up == (motor_state == ssgr_pkg::MODE_UP)))
		else $error("direction does not match motor state");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable({step_level, dir_up, driver_disabled,
		                                         motor_state, position, command_ignored})))
		else $error("waiting result changed");

endmodule

bind stepper_step_generator_ramp_unit ssgr_checker u_ssgr_checker (.*);

// ===== sim/stepper_step_generator_ramp_unit_tb.sv =====
module stepper_step_generator_ramp_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ssgr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [2:0] action = 3'd0;
	logic [ssgr_pkg::SPEED_W-1:0] speed = '0;
	logic limit_top = 1'b0;
	logic limit_bottom = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic step_level;
	logic dir_up;
	logic driver_disabled;
	logic [1:0] motor_state;
	logic signed [ssgr_pkg::POS_OUT_W-1:0] position;
	logic command_ignored;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ssgr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ssgr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// axis model state and its copy of the registers
	ssgr_pkg::mode_t ax_mode = ssgr_pkg::MODE_IDLE;
	logic [31:0] ax_steps = '0;
	logic [15:0] ax_period = '0;
	logic [15:0] ax_step_timer = '0;
	logic ax_pulse = 1'b0;
	logic [15:0] ax_goal = '0;
	logic [15:0] ax_ramp_period = '0;
	logic [7:0] ax_ramp_timer = '0;
	logic ax_dir_up = 1'b0;
	logic ax_disabled = 1'b0;
	logic [15:0] cfg_tick_rate = ssgr_pkg::TICK_RATE_RST;
	logic [15:0] cfg_start_speed = ssgr_pkg::START_SPEED_RST;
	logic [7:0] cfg_ramp_ticks = ssgr_pkg::RAMP_TICKS_RST;

	ssgr_pkg::res_t pending_status[$];
	ssgr_pkg::res_t head;
	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	stepper_step_generator_ramp_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.speed(speed),
		.limit_top(limit_top),
		.limit_bottom(limit_bottom),
		.empty(empty),
		.pop(pop),
		.step_level(step_level),
		.dir_up(dir_up),
		.driver_disabled(driver_disabled),
		.motor_state(motor_state),
		.position(position),
		.command_ignored(command_ignored),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] period_for_speed(logic [15:0] spd);
		int unsigned q;
		if (spd == 16'd0)
			return 16'd0;
		q = 32'(cfg_tick_rate) / 32'(spd);
		if (q < 1)
			q = 1;
		if (q > 32'hFFFF)
			q = 32'hFFFF;
		return q[15:0];
	endfunction

	function automatic void halt_axis(ssgr_pkg::mode_t m);
		ax_period = '0;
		ax_mode = m;
		ax_pulse = 1'b0;
	endfunction

	function automatic logic at_limit(logic top, logic bot);
		return (ax_mode == ssgr_pkg::MODE_UP && top) ||
			(ax_mode == ssgr_pkg::MODE_DOWN && bot);
	endfunction

	function automatic ssgr_pkg::res_t step_axis(ssgr_pkg::action_t act, logic [15:0] spd,
		logic top, logic bot);
		ssgr_pkg::res_t r;
		logic [15:0] goal;
		logic [15:0] start;
		logic ignored;
		logic lim;
		ignored = 1'b0;
		case (act)
			ssgr_pkg::ACT_TICK: begin
				if (ax_period != 16'd0) begin
					if (at_limit(top, bot)) begin
						halt_axis(ssgr_pkg::MODE_IDLE);
					end else begin
						if (ax_ramp_timer > 8'd0) begin
							ax_ramp_timer = ax_ramp_timer - 8'd1;
						end else begin
							ax_ramp_timer = cfg_ramp_ticks;
							if (ax_ramp_period > ax_goal) begin
								ax_ramp_period = ax_ramp_period - 16'd1;
								ax_period = ax_ramp_period;
							end
						end
						if (ax_step_timer > 16'd0) begin
							ax_step_timer = ax_step_timer - 16'd1;
						end else begin
							ax_step_timer = ax_period;
							if (!ax_pulse) begin
								ax_pulse = 1'b1;
								if (ax_mode == ssgr_pkg::MODE_UP)
									ax_steps = ax_steps + 32'd1;
								else if (ax_mode == ssgr_pkg::MODE_DOWN)
									ax_steps = ax_steps - 32'd1;
							end else begin
								ax_pulse = 1'b0;
							end
						end
					end
				end
			end
			ssgr_pkg::ACT_UP, ssgr_pkg::ACT_DOWN: begin
				lim = (act == ssgr_pkg::ACT_UP) ? top : bot;
				if (ax_mode == ssgr_pkg::MODE_ERROR || lim) begin
					ignored = 1'b1;
				end else begin
					ax_dir_up = (act == ssgr_pkg::ACT_UP);
					goal = period_for_speed(spd);
					start = period_for_speed(cfg_start_speed);
					if (start < goal)
						start = goal;
					ax_goal = goal;
					ax_ramp_period = start;
					ax_period = start;
					ax_step_timer = start;
					ax_ramp_timer = cfg_ramp_ticks;
					ax_mode = (act == ssgr_pkg::ACT_UP) ? ssgr_pkg::MODE_UP : ssgr_pkg::MODE_DOWN;
				end
			end
			ssgr_pkg::ACT_STOP: halt_axis(ssgr_pkg::MODE_IDLE);
			ssgr_pkg::ACT_ESTOP: begin
				halt_axis(ssgr_pkg::MODE_ERROR);
				ax_disabled = 1'b1;
			end
			ssgr_pkg::ACT_CLEAR: begin
				if (ax_mode == ssgr_pkg::MODE_ERROR)
					ax_mode = ssgr_pkg::MODE_IDLE;
				ax_disabled = 1'b0;
			end
			ssgr_pkg::ACT_ZERO: ax_steps = '0;
			default: begin
				if (at_limit(top, bot))
					halt_axis(ssgr_pkg::MODE_IDLE);
			end
		endcase
		r.step_level = ax_pulse;
		r.dir_up = ax_dir_up;
		r.driver_disabled = ax_disabled;
		r.motor_state = ax_mode;
		r.position = ax_steps;
		r.command_ignored = ignored;
		return r;
	endfunction

	// register writes and accepted items update the model at the edge they happen
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ssgr_pkg::CFG_TICK_RATE: cfg_tick_rate = cfg_data;
					ssgr_pkg::CFG_START_SPEED: cfg_start_speed = cfg_data;
					ssgr_pkg::CFG_RAMP_TICKS: cfg_ramp_ticks = cfg_data[7:0];
					default: ;
				endcase
			end
			if (push && !full)
				pending_status.push_back(step_axis(ssgr_pkg::action_t'(action), speed,
					limit_top, limit_bottom));
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_status.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result with no item waiting, expected none actual %0h",
					$time, position);
			end else begin
				head = pending_status.pop_front();
				check_field("step_level", head.step_level, step_level);
				check_field("dir_up", head.dir_up, dir_up);
				check_field("driver_disabled", head.driver_disabled, driver_disabled);
				check_field("motor_state", head.motor_state, motor_state);
				check_field("position", head.position, position);
				check_field("command_ignored", head.command_ignored, command_ignored);
			end
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic set_idling(idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 58;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				recv_stall_pct = 58;
			end
			default: begin
				sender_idle_pct = 12;
				recv_stall_pct = 12;
			end
		endcase
	endtask

	// push stays high after acceptance so back-to-back items need not drop and raise it again
	task automatic send_cmd(ssgr_pkg::action_t act, logic [15:0] spd, logic top, logic bot);
		while ($urandom_range(99) < sender_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		speed <= spd;
		limit_top <= top;
		limit_bottom <= bot;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [ssgr_pkg::CFG_IDX_W-1:0] idx,
		logic [ssgr_pkg::CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_speed();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return 16'd0;
		if (sel < 20)
			return 16'($urandom);
		if (sel < 26)
			return $urandom_range(1) ? 16'hFFFF : 16'd1;
		if (cfg_tick_rate == 16'd0)
			return 16'($urandom_range(1, 100));
		return 16'(cfg_tick_rate / $urandom_range(1, 6));
	endfunction

	// mostly a move followed by a run of ticks and polls, the rest single random items
	task automatic run_traffic(int n);
		int left;
		int burst;
		left = n;
		while (left > 0) begin
			if ($urandom_range(99) < 75) begin
				send_cmd($urandom_range(1) ? ssgr_pkg::ACT_UP : ssgr_pkg::ACT_DOWN, pick_speed(),
					$urandom_range(99) < 10, $urandom_range(99) < 10);
				left--;
				burst = $urandom_range(4, 60);
				while (burst > 0 && left > 0) begin
					send_cmd(($urandom_range(99) < 5) ? ssgr_pkg::ACT_POLL : ssgr_pkg::ACT_TICK,
						16'($urandom), $urandom_range(99) < 2, $urandom_range(99) < 2);
					burst--;
					left--;
				end
			end else begin
				send_cmd(ssgr_pkg::action_t'($urandom_range(7)), 16'($urandom),
					1'($urandom_range(1)), 1'($urandom_range(1)));
				left--;
			end
		end
	endtask

	task automatic test_directed_defaults();
		set_idling(IDLE_NONE);
		send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b1, 1'b1);       // zero period, nothing happens
		send_cmd(ssgr_pkg::ACT_POLL, 16'd0, 1'b1, 1'b1);
		send_cmd(ssgr_pkg::ACT_UP, 16'd100, 1'b1, 1'b0);       // refused at top limit
		send_cmd(ssgr_pkg::ACT_DOWN, 16'hFFFF, 1'b0, 1'b1);    // refused at bottom limit
		send_cmd(ssgr_pkg::ACT_UP, 16'hFFFF, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b0, 1'b1);
		send_cmd(ssgr_pkg::ACT_POLL, 16'd0, 1'b1, 1'b0);       // stops the upward move
		send_cmd(ssgr_pkg::ACT_DOWN, 16'd1, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b0, 1'b1);       // stops at bottom limit
		send_cmd(ssgr_pkg::ACT_ZERO, 16'd0, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_ESTOP, 16'd0, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_UP, 16'd10, 1'b0, 1'b0);        // refused in error
		send_cmd(ssgr_pkg::ACT_CLEAR, 16'd0, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_CLEAR, 16'd0, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_STOP, 16'd0, 1'b0, 1'b0);
	endtask

	task automatic test_config_extremes();
		set_idling(IDLE_BOTH);
		write_reg(ssgr_pkg::CFG_TICK_RATE, 16'd3);
		write_reg(ssgr_pkg::CFG_START_SPEED, 16'd1);
		write_reg(ssgr_pkg::CFG_RAMP_TICKS, 16'd0);
		// moving down from zero wraps the position below zero
		send_cmd(ssgr_pkg::ACT_DOWN, 16'd3, 1'b0, 1'b0);
		repeat (4) send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b0, 1'b0);
		// speed zero ramps the period down to zero and freezes
		send_cmd(ssgr_pkg::ACT_DOWN, 16'd0, 1'b0, 1'b0);
		repeat (4) send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b0, 1'b0);
		write_reg(ssgr_pkg::CFG_TICK_RATE, 16'd0);
		write_reg(ssgr_pkg::CFG_START_SPEED, 16'd0);
		write_reg(ssgr_pkg::CFG_RAMP_TICKS, 16'hFFFF);
		write_reg(CFG_UNUSED, 16'($urandom));
		send_cmd(ssgr_pkg::ACT_UP, 16'd7, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_UP, 16'd0, 1'b0, 1'b0);
		send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b0, 1'b0);
		write_reg(ssgr_pkg::CFG_TICK_RATE, 16'hFFFF);
		write_reg(ssgr_pkg::CFG_START_SPEED, 16'hFFFF);
		write_reg(ssgr_pkg::CFG_RAMP_TICKS, 16'd0);
		send_cmd(ssgr_pkg::ACT_UP, 16'd1, 1'b0, 1'b0);         // longest period
		send_cmd(ssgr_pkg::ACT_TICK, 16'd0, 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [15:0] rate;
		logic [15:0] start;
		logic [15:0] ramp;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					rate = 16'd40;
					start = 16'd4;
					ramp = 16'd2;
				end
				1: begin
					rate = ssgr_pkg::TICK_RATE_RST;
					start = ssgr_pkg::START_SPEED_RST;
					ramp = 16'(ssgr_pkg::RAMP_TICKS_RST);
				end
				2: begin
					rate = 16'hFFFF;
					start = 16'hFFFF;
					ramp = 16'd0;
				end
				3: begin
					rate = 16'd1;
					start = 16'd1;
					ramp = 16'd255;
				end
				4: begin
					rate = 16'd0;
					start = 16'd0;
					ramp = 16'd1;
				end
				5: begin
					rate = 16'd200;
					start = 16'd20;
					ramp = 16'd0;
				end
				6: begin
					rate = 16'($urandom_range(1, 300));
					start = 16'($urandom_range(1, 50));
					ramp = 16'($urandom);
				end
				default: begin
					rate = 16'($urandom);
					start = 16'($urandom);
					ramp = 16'($urandom);
				end
			endcase
			write_reg(ssgr_pkg::CFG_TICK_RATE, rate);
			write_reg(ssgr_pkg::CFG_START_SPEED, start);
			write_reg(ssgr_pkg::CFG_RAMP_TICKS, ramp);
			set_idling(idle_mode_t'(ph % 4));
			run_traffic(230);
		end
	endtask

	task automatic test_backpressure();
		write_reg(ssgr_pkg::CFG_TICK_RATE, 16'd40);
		write_reg(ssgr_pkg::CFG_START_SPEED, 16'd4);
		write_reg(ssgr_pkg::CFG_RAMP_TICKS, 16'd1);
		set_idling(IDLE_NONE);
		hold_seq++;
		run_traffic(80);
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_config_extremes();
		test_random_traffic();
		test_backpressure();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
